/* rtl/core/timestamp_text_to_epoch_seconds_defines.svh */
// ----------------------------------------------------------------------------
// Timestamp text to epoch seconds: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_TEXT_TO_EPOCH_SECONDS_DEFINES_SVH
`define TIMESTAMP_TEXT_TO_EPOCH_SECONDS_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define TTE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define TTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/tte_pkg.sv */
// ----------------------------------------------------------------------------
// tte_pkg
// Constants and the frame record shared by the parser, queue and converter.
// ----------------------------------------------------------------------------
`default_nettype none

package tte_pkg;

  localparam int DATE_LEN   = 14;
  localparam int OFFSET_LEN = 5;
  localparam int EPOCH_W    = 39;
  localparam int TDATA_W    = 40;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // One complete timestamp text as captured by the parser
  typedef struct packed {
    logic [DATE_LEN-1:0][7:0]   date_chars;
    logic [OFFSET_LEN-1:0][7:0] offset_chars;
    logic                       date_full;
    logic                       offset_full;
  } tte_rec_t;

endpackage

`default_nettype wire

/* rtl/core/tte_front.sv */
// ----------------------------------------------------------------------------
// tte_front
// Character parser: skips spaces, captures the date and offset characters,
// and emits one frame record on the character marked last.
// ----------------------------------------------------------------------------
`default_nettype none

module tte_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [7:0]       s_axis_tdata,   // [7:0] ch
  input  wire logic             s_axis_tlast,
  output logic                  rec_valid,
  input  wire logic             rec_ready,
  output tte_pkg::tte_rec_t     rec
);
  import tte_pkg::*;

  logic                       leading_skipped, leading_skipped_next;
  logic [4:0]                 date_count, date_count_next;
  logic                       gap_skipped, gap_skipped_next;
  logic [2:0]                 offset_count, offset_count_next;
  logic [DATE_LEN-1:0][7:0]   date_chars, date_chars_next;
  logic [OFFSET_LEN-1:0][7:0] offset_chars, offset_chars_next;
  logic                       taken;
  logic                       accept;

  // Take characters only while the queue can hold a finished frame
  assign s_axis_tready = rec_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Classify the character against the parse position
  always_comb begin
    taken                = 1'b0;
    leading_skipped_next = leading_skipped;
    date_count_next      = date_count;
    gap_skipped_next     = gap_skipped;
    offset_count_next    = offset_count;
    date_chars_next      = date_chars;
    offset_chars_next    = offset_chars;
    if (!leading_skipped) begin
      if (s_axis_tdata == CH_SPACE) begin
        taken = 1'b1;
      end else begin
        leading_skipped_next = 1'b1;
      end
    end
    if (!taken && date_count < 5'(DATE_LEN)) begin
      date_chars_next[date_count[3:0]] = s_axis_tdata;
      date_count_next = date_count + 5'd1;
      taken = 1'b1;
    end
    if (!taken && !gap_skipped) begin
      if (s_axis_tdata == CH_SPACE) begin
        taken = 1'b1;
      end else begin
        gap_skipped_next = 1'b1;
      end
    end
    if (!taken && offset_count < 3'(OFFSET_LEN)) begin
      offset_chars_next[offset_count] = s_axis_tdata;
      offset_count_next = offset_count + 3'd1;
    end
  end

  // Hold parse position; clear it after the last character
  always_ff @(posedge clk) begin
    if (rst) begin
      leading_skipped <= 1'b0;
      date_count      <= '0;
      gap_skipped     <= 1'b0;
      offset_count    <= '0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        leading_skipped <= 1'b0;
        date_count      <= '0;
        gap_skipped     <= 1'b0;
        offset_count    <= '0;
      end else begin
        leading_skipped <= leading_skipped_next;
        date_count      <= date_count_next;
        gap_skipped     <= gap_skipped_next;
        offset_count    <= offset_count_next;
      end
    end
  end

  // Character stores
  always_ff @(posedge clk) begin
    if (accept) begin
      date_chars   <= date_chars_next;
      offset_chars <= offset_chars_next;
    end
  end

  // Push the frame with the final character merged in
  assign rec_valid        = accept && s_axis_tlast;
  assign rec.date_chars   = date_chars_next;
  assign rec.offset_chars = offset_chars_next;
  assign rec.date_full    = (date_count_next == 5'(DATE_LEN));
  assign rec.offset_full  = (offset_count_next == 3'(OFFSET_LEN));

endmodule

`default_nettype wire

/* rtl/core/tte_queue.sv */
// ----------------------------------------------------------------------------
// tte_queue
// Two-entry frame queue between the parser and the converter.
// ----------------------------------------------------------------------------
`default_nettype none

module tte_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tte_pkg::tte_rec_t in_rec,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tte_pkg::tte_rec_t      out_rec
);
  import tte_pkg::*;

  localparam int DEPTH = 2;

  tte_rec_t   entries [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'(DEPTH));
  assign out_valid = (count != 2'd0);
  assign out_rec   = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_rec;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tte_back.sv */
// ----------------------------------------------------------------------------
// tte_back
// Converter: reads the fields of one frame, checks the date and forms the
// UTC epoch seconds through a short sequence sharing one divide-by-400 unit.
// ----------------------------------------------------------------------------
`default_nettype none

module tte_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rec_valid,
  output logic                   rec_ready,
  input  wire tte_pkg::tte_rec_t rec,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [39:0]            m_axis_tdata,   // [38:0] epoch_seconds
  output logic                   m_axis_tuser    // [0] fell_back
);
  import tte_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ERA, ST_LEAP, ST_YOE, ST_DAYS, ST_MUL, ST_SUM
  } state_t;

  // floor(x / 400) = (x * RECIP_400) >> 24 for x below 2**14
  localparam logic [15:0] RECIP_400 = 16'd41944;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // Optional minus, then digits up to the first non-digit; none gives 0
  function automatic logic signed [14:0] read_field(input logic [3:0][7:0] p,
                                                    input logic [2:0] len);
    logic        neg;
    logic        stop;
    logic [13:0] v;
    logic [2:0]  nd;
    logic signed [14:0] res;
    neg  = (p[0] == CH_MINUS);
    stop = 1'b0;
    v    = '0;
    nd   = '0;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < len && !(k == 0 && neg) && !stop) begin
        if (p[k] >= CH_ZERO && p[k] <= CH_NINE) begin
          v  = 14'(v * 14'd10) + 14'(p[k][3:0]);
          nd = nd + 3'd1;
        end else begin
          stop = 1'b1;
        end
      end
    end
    if (nd == 3'd0) begin
      res = '0;
    end else if (neg) begin
      res = -$signed({1'b0, v});
    end else begin
      res = $signed({1'b0, v});
    end
    return res;
  endfunction

  // Days before the month, year starting in March
  function automatic logic [8:0] cum_days(input logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd2:    d = leap ? 5'd29 : 5'd28;
      4'd4:    d = 5'd30;
      4'd6:    d = 5'd30;
      4'd9:    d = 5'd30;
      4'd11:   d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

  state_t state;

  // Parsed fields
  logic signed [14:0] year;
  logic signed [7:0]  mon, day, hh, mi, ss, off_hh, off_mi;
  logic               off_en, off_neg, short_text;
  // Intermediate results
  logic [13:0]        p_year, q_year;
  logic [4:0]         era_q, yq;
  logic               mon_ok, date_ok;
  logic [8:0]         yoe;
  logic signed [19:0] tod, off_val;
  logic signed [20:0] tod_off;
  logic signed [22:0] days;
  logic signed [38:0] prod;

  // Combinational helpers
  logic signed [15:0] yy_c;
  logic [13:0]        p_c, q_c, div_in;
  logic [29:0]        div_prod;
  logic [4:0]         quo;
  logic signed [19:0] tod_c, off_c;
  logic [8:0]         r_c;
  logic               leap_c;
  logic [4:0]         last_day_c;
  logic [3:0]         mp_c;
  logic [1:0]         yoe100_c;
  logic [17:0]        doe_c;
  logic signed [5:0]  era_c;
  logic signed [24:0] days_c;
  logic signed [39:0] prod_c;
  logic               out_free;

  assign rec_ready = (state == ST_IDLE);
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  // Shared divide-by-400: era in one step, leap year residue in the next
  always_comb begin
    yy_c     = (mon <= 8'sd2) ? 16'(year) - 16'sd1 : 16'(year);
    p_c      = 14'(yy_c + 16'sd1200);
    q_c      = 14'(16'(year) + 16'sd1200);
    div_in   = (state == ST_ERA) ? p_c : q_c;
    div_prod = {16'b0, div_in} * {14'b0, RECIP_400};
    quo      = div_prod[28:24];
  end

  // Time of day, offset, calendar checks and day count
  always_comb begin
    tod_c      = 20'(hh) * 20'sd3600 + 20'(mi) * 20'sd60 + 20'(ss);
    off_c      = 20'(off_hh) * 20'sd3600 + 20'(off_mi) * 20'sd60;
    r_c        = 9'(q_year - 14'(yq) * 14'd400);
    leap_c     = (r_c[1:0] == 2'd0) && !(r_c == 9'd100 || r_c == 9'd200 || r_c == 9'd300);
    last_day_c = month_days(mon[3:0], leap_c);
    mp_c       = (mon > 8'sd2) ? mon[3:0] - 4'd3 : mon[3:0] + 4'd9;
    yoe100_c   = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
    doe_c      = 18'(yoe) * 18'd365 + 18'(yoe[8:2]) - 18'(yoe100_c)
               + 18'(cum_days(mp_c)) + 18'(day[4:0]) - 18'd1;
    era_c      = $signed({1'b0, era_q}) - 6'sd3;
    days_c     = 25'(era_c) * 25'sd146097 + $signed({7'b0, doe_c}) - 25'sd719468;
    prod_c     = 40'(days) * 40'sd86400;
  end

  // Sequence one frame and hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Drop a taken result unless the final step replaces it
      if (m_axis_tvalid && m_axis_tready && state != ST_SUM) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (rec_valid) begin
            year       <= read_field(rec.date_chars[3:0], 3'd4);
            mon        <= 8'(read_field({16'h0, rec.date_chars[5:4]}, 3'd2));
            day        <= 8'(read_field({16'h0, rec.date_chars[7:6]}, 3'd2));
            hh         <= 8'(read_field({16'h0, rec.date_chars[9:8]}, 3'd2));
            mi         <= 8'(read_field({16'h0, rec.date_chars[11:10]}, 3'd2));
            ss         <= 8'(read_field({16'h0, rec.date_chars[13:12]}, 3'd2));
            off_hh     <= 8'(read_field({16'h0, rec.offset_chars[2:1]}, 3'd2));
            off_mi     <= 8'(read_field({16'h0, rec.offset_chars[4:3]}, 3'd2));
            off_en     <= rec.offset_full && (rec.offset_chars[0] == CH_PLUS ||
                                              rec.offset_chars[0] == CH_MINUS);
            off_neg    <= (rec.offset_chars[0] == CH_MINUS);
            short_text <= !rec.date_full;
            state      <= ST_ERA;
          end
        end
        ST_ERA: begin
          p_year <= p_c;
          era_q  <= quo;
          tod    <= tod_c;
          mon_ok <= (mon >= 8'sd1) && (mon <= 8'sd12);
          state  <= ST_LEAP;
        end
        ST_LEAP: begin
          q_year  <= q_c;
          yq      <= quo;
          off_val <= off_en ? (off_neg ? -off_c : off_c) : 20'sd0;
          state   <= ST_YOE;
        end
        ST_YOE: begin
          yoe     <= 9'(p_year - 14'(era_q) * 14'd400);
          date_ok <= mon_ok && (day >= 8'sd1) && (day <= $signed(8'(last_day_c)));
          tod_off <= 21'(tod) - 21'(off_val);
          state   <= ST_DAYS;
        end
        ST_DAYS: begin
          days  <= 23'(days_c);
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod  <= 39'(prod_c);
          state <= ST_SUM;
        end
        ST_SUM: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            if (date_ok && !short_text) begin
              m_axis_tdata <= {1'b0, prod + 39'(tod_off)};
              m_axis_tuser <= 1'b0;
            end else begin
              m_axis_tdata <= '0;
              m_axis_tuser <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/timestamp_text_to_epoch_seconds.sv */
// ----------------------------------------------------------------------------
// timestamp_text_to_epoch_seconds
// Converts a "YYYYMMDDHHMMSS [+HHMM]" character stream into UTC epoch seconds.
//
//   Channel  Dir  tdata               tuser      tlast
//   s_axis   in   [7:0] ch            -          last character of the text
//   m_axis   out  [38:0] epoch_secs   fell_back  -
//
// The parser takes one character per cycle. The converter takes a new frame
// only when idle, then runs its divide-by-400 steps and days * 86400 multiply.
// A two-entry frame queue lets the parser run ahead of the converter; the
// input stalls only when the queue is full.
// Reset (synchronous) clears the parse position, the queue and the output.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_text_to_epoch_seconds (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [38:0] epoch_seconds, [39] zero
  output logic             m_axis_tuser    // [0] fell_back
);
  import tte_pkg::*;

  logic     fq_valid, fq_ready;
  tte_rec_t fq_rec;
  logic     qb_valid, qb_ready;
  tte_rec_t qb_rec;

  tte_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .rec_valid     (fq_valid),
    .rec_ready     (fq_ready),
    .rec           (fq_rec)
  );

  tte_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_rec    (fq_rec),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_rec   (qb_rec)
  );

  tte_back u_back (
    .clk           (clk),
    .rst           (rst),
    .rec_valid     (qb_valid),
    .rec_ready     (qb_ready),
    .rec           (qb_rec),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

/* rtl/core/tte_checker.sv */
// ----------------------------------------------------------------------------
// tte_checker
// Port-level checks on the converter output, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timestamp_text_to_epoch_seconds_defines.svh"

module tte_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  // A stalled result holds
  `TTE_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // A fallback result carries zero seconds
  `TTE_ASSERT_SAME(a_fallback_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 40'd0, "fallback result is not zero")

  // Padding above the seconds field stays clear
  `TTE_ASSERT_SAME(a_pad_zero, m_axis_tvalid, m_axis_tdata[39] == 1'b0, "tdata padding bit set")

  // Leaving reset: input ready, no result pending
  `TTE_ASSERT_SAME(a_reset_state, $past(rst), s_axis_tready && !m_axis_tvalid, "bad state after reset")

endmodule

bind timestamp_text_to_epoch_seconds tte_checker u_tte_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
